// ===== rtl/sfr_pkg.sv =====
// ----------------------------------------------------------------------------
// sfr_pkg
// Shared constants and types for the sync-word frame receiver.
// ----------------------------------------------------------------------------
`default_nettype none

package sfr_pkg;

    localparam int BYTE_W      = 8;
    localparam int WORD_W      = 16;
    localparam int FRAME_LEN   = 18;
    localparam int HELD_COUNT  = 7;
    localparam int STAGE_BYTES = 2 * HELD_COUNT;
    localparam int STAGE_IDX_W = $clog2(STAGE_BYTES);
    localparam int POS_W       = $clog2(FRAME_LEN);

    localparam logic [WORD_W-1:0] START_WORD_RESET = 16'hABCD;

    localparam logic [POS_W-1:0] POS_HUNT    = POS_W'(0);
    localparam logic [POS_W-1:0] POS_HDR_HI  = POS_W'(1);
    localparam logic [POS_W-1:0] POS_BODY    = POS_W'(2);
    localparam logic [POS_W-1:0] POS_CHK_LO  = POS_W'(FRAME_LEN - 2);
    localparam logic [POS_W-1:0] POS_CHK_HI  = POS_W'(FRAME_LEN - 1);
    localparam logic [POS_W-1:0] POS_LIMIT   = POS_W'(FRAME_LEN);

    typedef logic [HELD_COUNT-1:0][WORD_W-1:0] held_words_t;

    typedef struct packed {
        logic        done;
        logic        ok;
        held_words_t words;
    } frame_evt_t;

endpackage

`default_nettype wire

// ===== rtl/sfr_in_stage.sv =====
// ----------------------------------------------------------------------------
// sfr_in_stage
// Input register for received bytes; holds a byte until the parser takes it.
// ----------------------------------------------------------------------------
`default_nettype none

module sfr_in_stage (
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic                      in_valid,
    output logic                           in_stall,
    input  wire logic [sfr_pkg::BYTE_W-1:0] rx_byte,
    input  wire logic                      take,
    output logic                           byte_valid,
    output logic [sfr_pkg::BYTE_W-1:0]     byte_data
);
    import sfr_pkg::*;

    logic              valid_reg;
    logic              valid_next;
    logic [BYTE_W-1:0] data_reg;
    logic              load;

    assign in_stall   = valid_reg && !take;
    assign load       = in_valid && !in_stall;
    assign valid_next = load ? 1'b1 : (take ? 1'b0 : valid_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            data_reg <= rx_byte;
        end
    end

    assign byte_valid = valid_reg;
    assign byte_data  = data_reg;

    a_take_needs_byte: assert property (@(posedge clk) disable iff (!rst_n)
        take |-> valid_reg)
        else $error("parser took a byte that is not there");

endmodule

`default_nettype wire

// ===== rtl/sfr_frame.sv =====
// ----------------------------------------------------------------------------
// sfr_frame
// Header hunt, body capture and running xor check of one frame.
// ----------------------------------------------------------------------------
`default_nettype none

module sfr_frame (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       cfg_wr_en,
    input  wire logic [sfr_pkg::WORD_W-1:0] cfg_wr_data,
    input  wire logic                       byte_valid,
    input  wire logic [sfr_pkg::BYTE_W-1:0] byte_data,
    input  wire logic                       out_free,
    output logic                            take,
    output sfr_pkg::frame_evt_t             evt
);
    import sfr_pkg::*;

    logic [WORD_W-1:0]      start_word_reg;
    logic [POS_W-1:0]       pos_reg;
    logic [POS_W-1:0]       pos_next;
    logic [POS_W-1:0]       pos_eff;
    logic [BYTE_W-1:0]      acc_lo_reg;
    logic [BYTE_W-1:0]      acc_lo_next;
    logic [BYTE_W-1:0]      acc_hi_reg;
    logic [BYTE_W-1:0]      acc_hi_next;
    logic [BYTE_W-1:0]      chk_lo_reg;
    logic [BYTE_W-1:0]      chk_lo_next;
    logic [BYTE_W-1:0]      stage_reg  [STAGE_BYTES];
    logic [BYTE_W-1:0]      stage_next [STAGE_BYTES];
    logic [STAGE_IDX_W-1:0] stage_idx;
    logic [BYTE_W-1:0]      start_lo;
    logic [BYTE_W-1:0]      start_hi;
    logic                   last;

    assign start_lo  = start_word_reg[BYTE_W-1:0];
    assign start_hi  = start_word_reg[WORD_W-1:BYTE_W];
    assign pos_eff   = (pos_reg >= POS_LIMIT) ? POS_HUNT : pos_reg;
    assign stage_idx = STAGE_IDX_W'(pos_eff - POS_BODY);
    assign last      = (pos_eff == POS_CHK_HI);
    assign take      = byte_valid && (!last || out_free);

    always_comb
    begin
        pos_next    = pos_reg;
        acc_lo_next = acc_lo_reg;
        acc_hi_next = acc_hi_reg;
        chk_lo_next = chk_lo_reg;
        stage_next  = stage_reg;
        evt.done    = 1'b0;
        evt.ok      = 1'b0;
        for (int k = 0; k < HELD_COUNT; k++)
        begin
            evt.words[k] = {stage_reg[2*k+1], stage_reg[2*k]};
        end
        if (take)
        begin
            priority if (pos_eff == POS_HUNT)
            begin
                if (byte_data == start_lo)
                begin
                    acc_lo_next = byte_data;
                    pos_next    = POS_HDR_HI;
                end
                else
                begin
                    pos_next = POS_HUNT;
                end
            end
            else if (pos_eff == POS_HDR_HI)
            begin
                if (byte_data == start_hi)
                begin
                    acc_hi_next = byte_data;
                    pos_next    = POS_BODY;
                end
                else if (byte_data == start_lo)
                begin
                    acc_lo_next = byte_data;
                    pos_next    = POS_HDR_HI;
                end
                else
                begin
                    pos_next = POS_HUNT;
                end
            end
            else if (pos_eff == POS_CHK_LO)
            begin
                chk_lo_next = byte_data;
                pos_next    = POS_CHK_HI;
            end
            else if (last)
            begin
                evt.done = 1'b1;
                evt.ok   = (acc_lo_reg == chk_lo_reg) && (acc_hi_reg == byte_data);
                pos_next = POS_HUNT;
            end
            else
            begin
                for (int i = 0; i < STAGE_BYTES; i++)
                begin
                    if (stage_idx == STAGE_IDX_W'(i))
                    begin
                        stage_next[i] = byte_data;
                    end
                end
                if (pos_eff[0])
                begin
                    acc_hi_next = acc_hi_reg ^ byte_data;
                end
                else
                begin
                    acc_lo_next = acc_lo_reg ^ byte_data;
                end
                pos_next = pos_eff + POS_W'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start_word_reg <= START_WORD_RESET;
            pos_reg        <= POS_HUNT;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                start_word_reg <= cfg_wr_data;
            end
            pos_reg <= pos_next;
        end
    end

    always_ff @(posedge clk)
    begin
        acc_lo_reg <= acc_lo_next;
        acc_hi_reg <= acc_hi_next;
        chk_lo_reg <= chk_lo_next;
        stage_reg  <= stage_next;
    end

    a_pos_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        pos_reg < POS_LIMIT)
        else $error("byte position out of frame");

    a_last_rewinds: assert property (@(posedge clk) disable iff (!rst_n)
        take && last |=> pos_reg == POS_HUNT)
        else $error("position not back to hunt after frame end");

    a_done_only_on_take: assert property (@(posedge clk) disable iff (!rst_n)
        evt.done |-> take && out_free)
        else $error("frame result without a free result register");

endmodule

`default_nettype wire

// ===== rtl/sfr_result.sv =====
// ----------------------------------------------------------------------------
// sfr_result
// Held feedback words and the result register toward the output channel.
// ----------------------------------------------------------------------------
`default_nettype none

module sfr_result (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire sfr_pkg::frame_evt_t evt,
    input  wire logic                out_stall,
    output logic                     out_free,
    output logic                     out_valid,
    output logic                     checksum_ok,
    output sfr_pkg::held_words_t     held
);
    import sfr_pkg::*;

    logic        valid_reg;
    logic        valid_next;
    logic        ok_reg;
    logic        ok_next;
    held_words_t held_reg;
    held_words_t held_next;

    assign out_free = !valid_reg || !out_stall;

    always_comb
    begin
        valid_next = valid_reg;
        ok_next    = ok_reg;
        held_next  = held_reg;
        if (evt.done)
        begin
            valid_next = 1'b1;
            ok_next    = evt.ok;
            if (evt.ok)
            begin
                held_next = evt.words;
            end
        end
        else if (!out_stall)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            ok_reg    <= 1'b0;
            held_reg  <= '0;
        end
        else
        begin
            valid_reg <= valid_next;
            ok_reg    <= ok_next;
            held_reg  <= held_next;
        end
    end

    assign out_valid   = valid_reg;
    assign checksum_ok = ok_reg;
    assign held        = held_reg;

    a_held_only_on_done: assert property (@(posedge clk) disable iff (!rst_n)
        !evt.done |=> $stable(held_reg))
        else $error("held feedback changed without a frame");

    a_fail_keeps_held: assert property (@(posedge clk) disable iff (!rst_n)
        evt.done && !evt.ok |=> $stable(held_reg) && !ok_reg)
        else $error("failed check touched held feedback");

endmodule

`default_nettype wire

// ===== rtl/sync_frame_receiver_xor_check_top.sv =====
// ----------------------------------------------------------------------------
// sync_frame_receiver_xor_check_top
// Result: the result register is loaded when the last frame byte is accepted
// and keeps its result for as long as out_stall holds it.
// Throughput: one byte per cycle unless stalled; input register feeds the parser, result
// register feeds the output, so a byte is taken while a result waits.
// A pending result stalls the input only when the next byte would end a frame.
// Reset: hunting the header, start word 0xABCD, held feedback all zero.
// ----------------------------------------------------------------------------
`default_nettype none

module sync_frame_receiver_xor_check_top (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       cfg_wr_en,
    input  wire logic [sfr_pkg::WORD_W-1:0] cfg_wr_data,
    input  wire logic                       in_valid,
    output logic                            in_stall,
    input  wire logic [sfr_pkg::BYTE_W-1:0] rx_byte,
    output logic                            out_valid,
    input  wire logic                       out_stall,
    output logic                            checksum_ok,
    output logic signed [sfr_pkg::WORD_W-1:0] command_one,
    output logic signed [sfr_pkg::WORD_W-1:0] command_two,
    output logic signed [sfr_pkg::WORD_W-1:0] speed_right,
    output logic signed [sfr_pkg::WORD_W-1:0] speed_left,
    output logic signed [sfr_pkg::WORD_W-1:0] battery_level,
    output logic signed [sfr_pkg::WORD_W-1:0] board_temperature,
    output logic [sfr_pkg::WORD_W-1:0]        led_bits
);
    import sfr_pkg::*;

    logic        take;
    logic        byte_valid;
    logic [BYTE_W-1:0] byte_data;
    logic        out_free;
    frame_evt_t  evt;
    held_words_t held;

    sfr_in_stage u_in_stage (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .rx_byte    (rx_byte),
        .take       (take),
        .byte_valid (byte_valid),
        .byte_data  (byte_data)
    );

    sfr_frame u_frame (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .byte_valid  (byte_valid),
        .byte_data   (byte_data),
        .out_free    (out_free),
        .take        (take),
        .evt         (evt)
    );

    sfr_result u_result (
        .clk         (clk),
        .rst_n       (rst_n),
        .evt         (evt),
        .out_stall   (out_stall),
        .out_free    (out_free),
        .out_valid   (out_valid),
        .checksum_ok (checksum_ok),
        .held        (held)
    );

    assign command_one       = $signed(held[0]);
    assign command_two       = $signed(held[1]);
    assign speed_right       = $signed(held[2]);
    assign speed_left        = $signed(held[3]);
    assign battery_level     = $signed(held[4]);
    assign board_temperature = $signed(held[5]);
    assign led_bits          = held[6];

endmodule

`default_nettype wire

// ===== tb/sv/sync_frame_receiver_xor_check_top_test.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// sync_frame_receiver_xor_check_top_test
// Feeds serial bytes, one byte per handshake, into the sync-word frame
// receiver under several start words. A built-in predictor tracks the header
// hunt, the 18-byte frame and the XOR check, and each result word is
// compared field by field with the oldest predicted frame result.
// ----------------------------------------------------------------------------

module sync_frame_receiver_xor_check_top_test;

    typedef struct packed {
        logic                 ok;
        sfr_pkg::held_words_t held;
    } frame_result_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic cfg_wr_en = 1'b0;
    logic [sfr_pkg::WORD_W-1:0] cfg_wr_data = '0;
    logic in_valid = 1'b0;
    logic in_stall;
    logic [sfr_pkg::BYTE_W-1:0] rx_byte = '0;
    logic out_valid;
    logic out_stall = 1'b0;
    logic checksum_ok;
    logic signed [sfr_pkg::WORD_W-1:0] command_one;
    logic signed [sfr_pkg::WORD_W-1:0] command_two;
    logic signed [sfr_pkg::WORD_W-1:0] speed_right;
    logic signed [sfr_pkg::WORD_W-1:0] speed_left;
    logic signed [sfr_pkg::WORD_W-1:0] battery_level;
    logic signed [sfr_pkg::WORD_W-1:0] board_temperature;
    logic [sfr_pkg::WORD_W-1:0] led_bits;

    // predictor state
    logic [sfr_pkg::WORD_W-1:0] sync_word = sfr_pkg::START_WORD_RESET;
    int                         frame_pos = 0;
    logic [sfr_pkg::BYTE_W-1:0] frame_copy [sfr_pkg::FRAME_LEN];
    sfr_pkg::held_words_t       held_copy = '0;

    logic [sfr_pkg::BYTE_W-1:0] byte_backlog [$];
    frame_result_t              frame_results_due [$];
    int                         mismatch_count = 0;
    logic                       steady = 1'b0;

    string field_names [sfr_pkg::HELD_COUNT] = '{"command_one", "command_two",
        "speed_right", "speed_left", "battery_level", "board_temperature", "led_bits"};

    sync_frame_receiver_xor_check_top uut (
        .clk               (clk),
        .rst_n             (rst_n),
        .cfg_wr_en         (cfg_wr_en),
        .cfg_wr_data       (cfg_wr_data),
        .in_valid          (in_valid),
        .in_stall          (in_stall),
        .rx_byte           (rx_byte),
        .out_valid         (out_valid),
        .out_stall         (out_stall),
        .checksum_ok       (checksum_ok),
        .command_one       (command_one),
        .command_two       (command_two),
        .speed_right       (speed_right),
        .speed_left        (speed_left),
        .battery_level     (battery_level),
        .board_temperature (board_temperature),
        .led_bits          (led_bits)
    );

    always #5 clk = ~clk;

    function automatic logic [sfr_pkg::WORD_W-1:0] frame_word(input int k);
        return {frame_copy[2 * k + 1], frame_copy[2 * k]};
    endfunction

    task automatic parse_byte(input logic [sfr_pkg::BYTE_W-1:0] b);
        logic [sfr_pkg::WORD_W-1:0] sum;
        frame_result_t              r;
        sum = '0;
        if (frame_pos == 0)
        begin
            if (b == sync_word[7:0])
            begin
                frame_copy[0] = b;
                frame_pos = 1;
            end
        end
        else if (frame_pos == 1)
        begin
            if (b == sync_word[15:8])
            begin
                frame_copy[1] = b;
                frame_pos = 2;
            end
            else if (b == sync_word[7:0])
            begin
                frame_copy[0] = b;
            end
            else
            begin
                frame_pos = 0;
            end
        end
        else
        begin
            frame_copy[frame_pos] = b;
            frame_pos++;
            if (frame_pos == sfr_pkg::FRAME_LEN)
            begin
                frame_pos = 0;
                for (int k = 0; k < 8; k++)
                    sum ^= frame_word(k);
                r.ok = (sum == frame_word(8));
                if (r.ok)
                begin
                    for (int k = 0; k < sfr_pkg::HELD_COUNT; k++)
                        held_copy[k] = frame_word(k + 1);
                end
                r.held = held_copy;
                frame_results_due.push_back(r);
            end
        end
    endtask

    task automatic report_mismatch(input string msg);
        mismatch_count++;
        if (mismatch_count <= 40)
            $display("mismatch at %0t: %s", $time, msg);
    endtask

    task automatic check_result();
        frame_result_t        want;
        sfr_pkg::held_words_t got;
        got = {led_bits, board_temperature, battery_level, speed_left,
               speed_right, command_two, command_one};
        if (frame_results_due.size() == 0)
        begin
            report_mismatch("result with no frame pending");
            return;
        end
        want = frame_results_due.pop_front();
        if (checksum_ok !== want.ok)
            report_mismatch($sformatf("checksum_ok got %b want %b", checksum_ok, want.ok));
        for (int k = 0; k < sfr_pkg::HELD_COUNT; k++)
        begin
            if (got[k] !== want.held[k])
                report_mismatch($sformatf("%s got %h want %h",
                                          field_names[k], got[k], want.held[k]));
        end
    endtask

    // driver
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
        end
        else
        begin
            if (in_valid && !in_stall)
                parse_byte(rx_byte);
            if (!in_valid || !in_stall)
            begin
                if (byte_backlog.size() != 0 && (steady || $urandom_range(99) >= 17))
                begin
                    in_valid <= 1'b1;
                    rx_byte  <= byte_backlog.pop_front();
                end
                else
                begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // monitor
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            out_stall <= 1'b0;
        end
        else
        begin
            if (out_valid && !out_stall)
                check_result();
            out_stall <= !steady && ($urandom_range(99) < 17);
        end
    end

    task automatic push_word(input logic [sfr_pkg::WORD_W-1:0] w);
        byte_backlog.push_back(w[7:0]);
        byte_backlog.push_back(w[15:8]);
    endtask

    task automatic push_frame(input logic good);
        logic [sfr_pkg::WORD_W-1:0] sum;
        logic [sfr_pkg::WORD_W-1:0] w;
        sum = sync_word;
        push_word(sync_word);
        for (int k = 0; k < sfr_pkg::HELD_COUNT; k++)
        begin
            case ($urandom_range(7))
                0: w = 16'h0000;
                1: w = 16'hFFFF;
                2: w = 16'h8000;
                3: w = 16'h7FFF;
                default: w = 16'($urandom_range(16'hFFFF));
            endcase
            push_word(w);
            sum ^= w;
        end
        if (!good)
            sum ^= 16'($urandom_range(16'hFFFF, 1));
        push_word(sum);
    endtask

    task automatic push_random_part(input int count);
        logic [sfr_pkg::BYTE_W-1:0] b;
        int                         pick;
        for (int n = 0; n < count; n++)
        begin
            pick = $urandom_range(99);
            if (pick < 65)
            begin
                push_frame(1'b1);
            end
            else if (pick < 80)
            begin
                push_frame(1'b0);
            end
            else if (pick < 90)
            begin
                // header broken at the second byte
                byte_backlog.push_back(sync_word[7:0]);
                do
                    b = 8'($urandom_range(255));
                while (b == sync_word[7:0] || b == sync_word[15:8]);
                byte_backlog.push_back(b);
            end
            else
            begin
                repeat ($urandom_range(6, 1))
                    byte_backlog.push_back(8'($urandom_range(255)));
            end
        end
    endtask

    task automatic settle();
        do
            @(negedge clk);
        while (byte_backlog.size() != 0 || in_valid || frame_results_due.size() != 0);
        repeat (4) @(negedge clk);
    endtask

    task automatic write_sync_word(input logic [sfr_pkg::WORD_W-1:0] v);
        @(posedge clk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= v;
        sync_word = v;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        @(negedge clk);
    endtask

    initial
    begin
        logic [sfr_pkg::WORD_W-1:0] sum;
        logic [sfr_pkg::WORD_W-1:0] settings [$];
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // extremes, header restarts, then one good frame
        byte_backlog.push_back(8'h00);
        byte_backlog.push_back(8'hFF);
        byte_backlog.push_back(8'hCD);
        byte_backlog.push_back(8'h12);
        byte_backlog.push_back(8'hCD);
        byte_backlog.push_back(8'hCD);
        byte_backlog.push_back(8'hAB);
        sum = 16'hABCD;
        settings.delete();
        settings = '{16'hFFFF, 16'h0000, 16'h8000, 16'h7FFF, 16'h00FF, 16'hFF00, 16'h5A5A};
        foreach (settings[i])
        begin
            push_word(settings[i]);
            sum ^= settings[i];
        end
        push_word(sum);
        push_random_part(13);

        settings = '{16'h0000, 16'hFFFF, 16'h5555, 16'(($urandom_range(16'hFFFF))),
                     16'h00FF, 16'hABCD};
        foreach (settings[i])
        begin
            settle();
            write_sync_word(settings[i]);
            steady = (i == settings.size() - 1);
            push_random_part(13);
        end

        settle();
        if (mismatch_count == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

    initial
    begin
        #2000000;
        $display("TEST FAILED");
        $finish;
    end

endmodule
